>>> rtl/susi_pkg.sv
// Package for the sorted unique set insert unit: sizes, command and status codes,
// and the structs passed between the entry cells, the group encoders and the top level.
// No dependencies.
`default_nettype none

package susi_pkg;

   // Capacity of the list and derived widths
   localparam int CAPACITY   = 64;
   localparam int KEY_W      = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE = 8;
   localparam int GSEL_W     = $clog2(GROUP_SIZE);
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // Field widths at the ports
   localparam int CMD_W    = 2;
   localparam int RIDX_W   = 6;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OOR  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

   // Per-cell control from the top level
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // Per-cell compare results
   typedef struct packed {
      logic             ge;     // empty, or entry >= key
      logic             eq;     // valid and entry == key
      logic             hit;    // valid and selected for read
      logic [KEY_W-1:0] rdata;  // entry when hit, else zero
   } cell_flags_type;

   // Registered summary of one group of cells
   typedef struct packed {
      logic              any_ge;
      logic              any_eq;
      logic              any_hit;
      logic [GSEL_W-1:0] first_ge;
      logic [KEY_W-1:0]  rdata;
   } grp_sum_type;

endpackage

`default_nettype wire

>>> rtl/susi_cell.sv
// One entry cell of the sorted list: holds a key and its valid bit, compares against
// the broadcast key and shifts in from its lower neighbor on insert. Uses susi_pkg.
`default_nettype none

module susi_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire susi_pkg::cell_ctl_type      ctl,
   input  wire logic [susi_pkg::KEY_W-1:0]  key,
   input  wire logic                        rd_sel,
   input  wire logic [susi_pkg::KEY_W-1:0]  prev_entry,
   input  wire logic                        prev_ge,
   input  wire logic                        prev_valid,
   output logic      [susi_pkg::KEY_W-1:0]  entry,
   output logic                             valid,
   output susi_pkg::cell_flags_type         flags
);

   logic [susi_pkg::KEY_W-1:0] entry_ff, entry_in;
   logic                       valid_ff, valid_in;
   logic                       ge;

   assign ge = !valid_ff || (entry_ff >= key);

   always_comb begin
      flags.ge    = ge;
      flags.eq    = valid_ff && (entry_ff == key);
      flags.hit   = valid_ff && rd_sel;
      flags.rdata = (valid_ff && rd_sel) ? entry_ff : '0;
   end

   // Take the neighbor's key if it is also at or above the insert point, else the new key
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift && ge) begin
         entry_in = prev_ge ? prev_entry : key;
         valid_in = valid_ff | prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

>>> rtl/susi_group.sv
// Group encoder: reduces the compare flags of a group of cells to one registered
// summary (first cell at or above the key, duplicate, read hit and data). Uses susi_pkg.
`default_nettype none

module susi_group (
   input  wire logic                     clock,
   input  wire susi_pkg::cell_flags_type flags [susi_pkg::GROUP_SIZE],
   output susi_pkg::grp_sum_type         sum
);

   susi_pkg::grp_sum_type sum_ff, sum_in;

   always_comb begin
      sum_in = '0;
      // scan from the top so the lowest flagged cell wins
      for (int c = susi_pkg::GROUP_SIZE - 1; c >= 0; c--) begin
         if (flags[c].ge) begin
            sum_in.first_ge = susi_pkg::GSEL_W'(c);
         end
      end
      for (int c = 0; c < susi_pkg::GROUP_SIZE; c++) begin
         sum_in.any_ge  = sum_in.any_ge  | flags[c].ge;
         sum_in.any_eq  = sum_in.any_eq  | flags[c].eq;
         sum_in.any_hit = sum_in.any_hit | flags[c].hit;
         sum_in.rdata   = sum_in.rdata   | flags[c].rdata;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

>>> rtl/sorted_unique_set_insert_unit.sv
// Top level of the sorted unique set insert unit: request/response stream ports,
// command sequencer, row of entry cells and group encoders. Uses susi_pkg,
// susi_cell and susi_group.
//
// The unit keeps an ascending list of up to CAPACITY distinct 32-bit keys in a row of
// cells. Requests carry a command in req_tuser: insert key, read entry at index, or
// clear. Every request with a defined command gives exactly one response; command
// code 3 is accepted and dropped. Each request passes through an accept step, a
// compare step in which every cell compares its key with the request key and the
// groups of eight cells register their summaries, and an apply step in which the
// group summaries are combined, the cells shift up behind the insert point and the
// response register is loaded. A new request is taken once the previous one has
// reached the response register. The apply step waits while the previous response
// is still held in that register, so a stalled response output holds the next
// request in its apply step and keeps req_tready low until the response is taken.
// Without stalls the request rate is set by the accept, compare and apply steps of
// the sequencer. The list comes out of reset empty; no clearing pass is needed
// since each cell has its own valid bit.
`default_nettype none

module sorted_unique_set_insert_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = key_value[31:0], read_index[37:32], zero pad [39:38]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // tuser = command[1:0]
   input  wire logic [1:0]  req_tuser,
   // response: tdata = position[6:0], read_data[38:7], entry_count[45:39], pad [47:46]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,
   // tuser = status[2:0]
   output logic      [2:0]  rsp_tuser
);

   localparam int NCELL = susi_pkg::NUM_GROUPS * susi_pkg::GROUP_SIZE;

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'b001,
      FSM_CMP   = 3'b010,
      FSM_APPLY = 3'b100
   } fsm_type;

   fsm_type                                 state_ff, state_in;
   logic [susi_pkg::CMD_W-1:0]              cmd_ff;
   logic [susi_pkg::KEY_W-1:0]              key_ff;
   logic [susi_pkg::RIDX_W-1:0]             ridx_ff;
   logic [susi_pkg::CNT_W-1:0]              count_ff, count_in;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [susi_pkg::STATUS_W-1:0]           rsp_status_ff, rsp_status_in;
   logic [susi_pkg::POS_W-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [susi_pkg::KEY_W-1:0]              rsp_data_ff, rsp_data_in;
   logic [susi_pkg::COUNT_W-1:0]            rsp_count_ff, rsp_count_in;

   logic                                    req_accept;
   logic                                    apply_go;
   susi_pkg::cell_ctl_type                  ctl;

   logic [susi_pkg::KEY_W-1:0]              entry [susi_pkg::CAPACITY];
   logic                                    valid [susi_pkg::CAPACITY];
   susi_pkg::cell_flags_type                flags [NCELL];
   susi_pkg::grp_sum_type                   sums  [susi_pkg::NUM_GROUPS];

   logic                                    dup, hit, full;
   logic [susi_pkg::CNT_W-1:0]              place;
   logic [susi_pkg::KEY_W-1:0]              rdata;

   // low 7 bits of a count-width value, zero-extended when the count is narrower
   function automatic logic [6:0] low7(input logic [susi_pkg::CNT_W-1:0] v);
      logic [susi_pkg::CNT_W+6:0] wide;
      wide = {7'b0, v};
      return wide[6:0];
   endfunction

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == FSM_IDLE);
   // hold the apply step while the previous response still waits
   assign apply_go   = (state_ff == FSM_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign full       = (count_ff == susi_pkg::CNT_W'(susi_pkg::CAPACITY));

   // ---------------------------------------------------------------------------------
   // Cell row: cell 0 sees an always-valid neighbor that is below the key
   // ---------------------------------------------------------------------------------
   for (genvar i = 0; i < susi_pkg::CAPACITY; i++) begin : g_cell
      logic [susi_pkg::KEY_W-1:0] prev_entry;
      logic                       prev_ge;
      logic                       prev_valid;
      logic                       rd_sel;

      if (i == 0) begin : g_first
         assign prev_entry = key_ff;
         assign prev_ge    = 1'b0;
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_entry = entry[i-1];
         assign prev_ge    = flags[i-1].ge;
         assign prev_valid = valid[i-1];
      end

      assign rd_sel = (32'(ridx_ff) == 32'(i));

      susi_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_ff),
         .rd_sel     (rd_sel),
         .prev_entry (prev_entry),
         .prev_ge    (prev_ge),
         .prev_valid (prev_valid),
         .entry      (entry[i]),
         .valid      (valid[i]),
         .flags      (flags[i])
      );
   end

   // pad cells that fill the last group report nothing
   for (genvar i = susi_pkg::CAPACITY; i < NCELL; i++) begin : g_pad
      assign flags[i] = '0;
   end

   // ---------------------------------------------------------------------------------
   // Group encoders, registered at the end of the compare cycle
   // ---------------------------------------------------------------------------------
   for (genvar g = 0; g < susi_pkg::NUM_GROUPS; g++) begin : g_grp
      susi_pkg::cell_flags_type gflags [susi_pkg::GROUP_SIZE];
      for (genvar c = 0; c < susi_pkg::GROUP_SIZE; c++) begin : g_map
         assign gflags[c] = flags[g*susi_pkg::GROUP_SIZE + c];
      end
      susi_group u_group (
         .clock (clock),
         .flags (gflags),
         .sum   (sums[g])
      );
   end

   // Combine the group summaries: the lowest group with a cell at or above the key
   // gives the insert point, which is also where an equal key lies
   always_comb begin
      dup   = 1'b0;
      hit   = 1'b0;
      rdata = '0;
      place = '0;
      for (int g = susi_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
         if (sums[g].any_ge) begin
            place = susi_pkg::CNT_W'(g * susi_pkg::GROUP_SIZE)
                  + susi_pkg::CNT_W'(sums[g].first_ge);
         end
      end
      for (int g = 0; g < susi_pkg::NUM_GROUPS; g++) begin
         dup   = dup | sums[g].any_eq;
         hit   = hit | sums[g].any_hit;
         rdata = rdata | sums[g].rdata;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer and response
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ctl           = '0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         FSM_IDLE: begin
            // drop requests with the unused command code
            if (req_accept && (req_tuser == susi_pkg::CMD_INSERT ||
                               req_tuser == susi_pkg::CMD_READ ||
                               req_tuser == susi_pkg::CMD_CLEAR)) begin
               state_in = FSM_CMP;
            end
         end
         FSM_CMP: begin
            state_in = FSM_APPLY;
         end
         FSM_APPLY: begin
            if (apply_go) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               rsp_pos_in   = '0;
               rsp_data_in  = '0;
               case (cmd_ff)
                  susi_pkg::CMD_INSERT: begin
                     if (dup) begin
                        rsp_status_in = susi_pkg::ST_DUPLICATE;
                        rsp_pos_in    = low7(place);
                     end else if (full) begin
                        rsp_status_in = susi_pkg::ST_FULL;
                     end else begin
                        rsp_status_in = susi_pkg::ST_INSERTED;
                        rsp_pos_in    = low7(place);
                        ctl.shift     = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  susi_pkg::CMD_READ: begin
                     if (hit) begin
                        rsp_status_in = susi_pkg::ST_READ_OK;
                        rsp_data_in   = rdata;
                     end else begin
                        rsp_status_in = susi_pkg::ST_READ_OOR;
                     end
                  end
                  default: begin
                     rsp_status_in = susi_pkg::ST_CLEARED;
                     ctl.clear     = 1'b1;
                     count_in      = '0;
                  end
               endcase
               rsp_count_in = low7(count_in);
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_tuser;
         key_ff  <= req_tdata[31:0];
         ridx_ff <= req_tdata[37:32];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_data_ff, rsp_pos_ff};

endmodule

`default_nettype wire

>>> rtl/susi_checker.sv
// Port-level checker for the sorted unique set insert unit, bound to the top level.
// Uses susi_pkg for status codes.
`default_nettype none

module susi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // an inserted or duplicate key lies inside the stored list
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == susi_pkg::ST_INSERTED ||
                     rsp_tuser == susi_pkg::ST_DUPLICATE)
      |-> rsp_tdata[6:0] < rsp_tdata[45:39])
      else $error("position beyond entry count");

   // read data is zero unless a read succeeded
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != susi_pkg::ST_READ_OK |-> rsp_tdata[38:7] == 32'd0)
      else $error("read data set on non-read response");

   // a clear leaves the list empty
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == susi_pkg::ST_CLEARED |-> rsp_tdata[45:39] == 7'd0)
      else $error("entry count nonzero after clear");

endmodule

bind sorted_unique_set_insert_unit susi_checker u_susi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> tb/sv/sorted_unique_set_insert_unit_test.sv
// Self-checking testbench for the sorted unique set insert unit: directed table, then
// random command sequences, checked against a behavioral copy of the key list.
// Depends on susi_pkg and sorted_unique_set_insert_unit.
`timescale 1ns / 100ps

module sorted_unique_set_insert_unit_test;

   // Command code 3 has no meaning; the unit must swallow it without a response
   localparam logic [susi_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 1650;
   localparam int QUIET_ITEMS   = 1400;   // drop all idling past this point
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      logic [susi_pkg::STATUS_W-1:0] status;
      logic [susi_pkg::POS_W-1:0]    position;
      logic [susi_pkg::KEY_W-1:0]    read_data;
      logic [susi_pkg::COUNT_W-1:0]  entry_count;
   } rsp_fields_type;

   typedef struct packed {
      logic [susi_pkg::CMD_W-1:0]  command;
      logic [susi_pkg::KEY_W-1:0]  key;
      logic [susi_pkg::RIDX_W-1:0] index;
      bit                          pinned;    // use the typed-in result, not the predictor
      rsp_fields_type              result;
   } stim_row_type;

   localparam rsp_fields_type NO_RESULT = '0;

   // Directed table. Typed results are the ones obvious from the rules: empty list,
   // extreme keys, duplicates, out-of-range reads and clears. The rest use the predictor.
   stim_row_type directed_rows [0:23] = '{
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_READ_OOR,  7'd0, 32'h0, 7'd0}},
      '{susi_pkg::CMD_CLEAR,  32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_CLEARED,   7'd0, 32'h0, 7'd0}},
      '{susi_pkg::CMD_INSERT, 32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_INSERTED,  7'd0, 32'h0, 7'd1}},
      '{susi_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b1,
        '{susi_pkg::ST_INSERTED,  7'd1, 32'h0, 7'd2}},
      '{susi_pkg::CMD_INSERT, 32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_DUPLICATE, 7'd0, 32'h0, 7'd2}},
      '{susi_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1,
        '{susi_pkg::ST_DUPLICATE, 7'd1, 32'h0, 7'd2}},
      '{CMD_UNUSED,           32'hA5A5_A5A5, 6'd63, 1'b0, NO_RESULT},
      '{susi_pkg::CMD_READ,   32'hFFFF_FFFF, 6'd1,  1'b1,
        '{susi_pkg::ST_READ_OK,   7'd0, 32'hFFFF_FFFF, 7'd2}},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_READ_OK,   7'd0, 32'h0, 7'd2}},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd63, 1'b1,
        '{susi_pkg::ST_READ_OOR,  7'd0, 32'h0, 7'd2}},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd2,  1'b1,
        '{susi_pkg::ST_READ_OOR,  7'd0, 32'h0, 7'd2}},
      '{susi_pkg::CMD_INSERT, 32'h8000_0000, 6'd0,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_INSERT, 32'h7FFF_FFFF, 6'd0,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_INSERT, 32'h0000_0001, 6'd0,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_INSERT, 32'hFFFF_FFFE, 6'd0,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd2,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd5,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_INSERT, 32'h5555_5555, 6'd42, 1'b0, NO_RESULT},
      '{susi_pkg::CMD_INSERT, 32'hAAAA_AAAA, 6'd21, 1'b0, NO_RESULT},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd3,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 6'd63, 1'b1,
        '{susi_pkg::ST_CLEARED,   7'd0, 32'h0, 7'd0}},
      '{susi_pkg::CMD_READ,   32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_READ_OOR,  7'd0, 32'h0, 7'd0}},
      '{CMD_UNUSED,           32'h5A5A_5A5A, 6'd0,  1'b0, NO_RESULT},
      '{susi_pkg::CMD_CLEAR,  32'h0000_0000, 6'd0,  1'b1,
        '{susi_pkg::ST_CLEARED,   7'd0, 32'h0, 7'd0}}
   };

   // Clock, reset and stream signals; those driven here are known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;     // key_value[31:0], read_index[37:32], pad[39:38]
   logic [1:0]  req_tuser  = '0;     // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // position[6:0], read_data[38:7], entry_count[45:39]
   logic [2:0]  rsp_tuser;           // status[2:0]

   // Shadow copy of the key list held by the unit
   logic [susi_pkg::KEY_W-1:0] shadow_keys [susi_pkg::CAPACITY];
   int                         shadow_count = 0;

   stim_row_type               issued_q [$];    // requests presented, oldest first
   rsp_fields_type             expected_q [$];  // responses still owed by the unit
   logic [susi_pkg::KEY_W-1:0] recent_keys [$];

   int  error_count  = 0;
   int  sent_count   = 0;
   int  cycle_count  = 0;
   bit  req_idle_on  = 1'b1;
   bit  rsp_idle_on  = 1'b1;

   // Monitor scratch
   stim_row_type   accepted_row;
   rsp_fields_type predicted;
   rsp_fields_type got;
   rsp_fields_type want;
   bit             produces;

   sorted_unique_set_insert_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Apply one command to the shadow list and work out the response it owes
   function automatic void apply_to_shadow(input logic [susi_pkg::CMD_W-1:0] cmd,
                                           input logic [susi_pkg::KEY_W-1:0] key,
                                           input logic [susi_pkg::RIDX_W-1:0] idx,
                                           output bit produced,
                                           output rsp_fields_type r);
      int n;
      int place;
      n = shadow_count;
      place = n;
      produced = 1'b1;
      r = '0;
      case (cmd)
         susi_pkg::CMD_INSERT: begin
            // first stored key not smaller than the new one
            for (int i = 0; i < n; i++) begin
               if (place == n && shadow_keys[i] >= key) place = i;
            end
            if (place < n && shadow_keys[place] == key) begin
               r.status   = susi_pkg::ST_DUPLICATE;
               r.position = susi_pkg::POS_W'(place);
            end else if (n >= susi_pkg::CAPACITY) begin
               r.status = susi_pkg::ST_FULL;
            end else begin
               for (int i = n; i > place; i--) shadow_keys[i] = shadow_keys[i-1];
               shadow_keys[place] = key;
               shadow_count = n + 1;
               r.status   = susi_pkg::ST_INSERTED;
               r.position = susi_pkg::POS_W'(place);
            end
         end
         susi_pkg::CMD_READ: begin
            if (int'(idx) < n) begin
               r.status    = susi_pkg::ST_READ_OK;
               r.read_data = shadow_keys[idx];
            end else begin
               r.status = susi_pkg::ST_READ_OOR;
            end
         end
         susi_pkg::CMD_CLEAR: begin
            shadow_count = 0;
            r.status = susi_pkg::ST_CLEARED;
         end
         default: produced = 1'b0;
      endcase
      r.entry_count = susi_pkg::COUNT_W'(shadow_count);
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [susi_pkg::KEY_W-1:0] got_v,
                                  input logic [susi_pkg::KEY_W-1:0] want_v);
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got_v, want_v);
      error_count++;
   endtask

   // Present one request and hold it until it is taken. A random idle burst may
   // come first; while idle, scribble on the data lines since they are don't-care.
   task automatic send_request(input logic [susi_pkg::CMD_W-1:0] cmd,
                               input logic [susi_pkg::KEY_W-1:0] key,
                               input logic [susi_pkg::RIDX_W-1:0] idx,
                               input bit pinned = 1'b0,
                               input rsp_fields_type typed = '0);
      stim_row_type row;
      row.command = cmd;
      row.key     = key;
      row.index   = idx;
      row.pinned  = pinned;
      row.result  = typed;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {8'($urandom), 32'($urandom)};
         req_tuser  <= 2'($urandom);
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      issued_q = {issued_q, row};
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, idx, key};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      if (cmd != CMD_UNUSED) sent_count++;
      if (cmd == susi_pkg::CMD_INSERT) begin
         recent_keys = {recent_keys, key};
         if (recent_keys.size() > 16) void'(recent_keys.pop_front());
      end
   endtask

   // Pick a key near a small window, so that duplicates and close neighbors are common
   function automatic logic [susi_pkg::KEY_W-1:0] window_key(
         input logic [susi_pkg::KEY_W-1:0] base);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      if (r == 2 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      return base + 32'($urandom_range(0, 23));
   endfunction

   function automatic logic [susi_pkg::KEY_W-1:0] wide_key();
      if ($urandom_range(0, 5) == 0 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      return 32'($urandom);
   endfunction

   // Watch both handshakes at the clock edge: predict on each accepted request,
   // check each accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accepted_row = issued_q.size() > 0 ? issued_q.pop_front() : '0;
            apply_to_shadow(req_tuser, req_tdata[31:0], req_tdata[37:32], produces, predicted);
            if (produces)
               expected_q = {expected_q, (accepted_row.pinned ? accepted_row.result
                                                               : predicted)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser;
            got.position    = rsp_tdata[6:0];
            got.read_data   = rsp_tdata[38:7];
            got.entry_count = rsp_tdata[45:39];
            if (expected_q.size() == 0) begin
               report_mismatch("response with none outstanding, status", 32'(got.status), 0);
            end else begin
               want = expected_q.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.position != want.position)
                  report_mismatch("position", 32'(got.position), 32'(want.position));
               if (got.read_data != want.read_data)
                  report_mismatch("read_data", got.read_data, want.read_data);
               if (got.entry_count != want.entry_count)
                  report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            end
         end
      end
   end

   // Watchdog: fail the run once the cycle count reaches CYCLE_LIMIT
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response side: accept by default, stall now and then in bursts
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Request side: reset, directed table, random sequences, drain
   initial begin
      logic [susi_pkg::KEY_W-1:0] base;
      int                         mode;
      int                         len;
      int                         pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].command, directed_rows[i].key, directed_rows[i].index,
                      directed_rows[i].pinned, directed_rows[i].result);

      while (sent_count < $size(directed_rows) + RANDOM_ITEMS) begin
         // run quiet near the end so back-to-back traffic is covered as well
         if (sent_count > QUIET_ITEMS) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         mode = $urandom_range(0, 2);
         if (mode == 0) begin
            // fill past capacity, read across the full list, then hit it while full
            send_request(susi_pkg::CMD_CLEAR, 32'($urandom), 6'($urandom));
            len = $urandom_range(64, 78);
            repeat (len) begin
               send_request(susi_pkg::CMD_INSERT, wide_key(), 6'($urandom));
               if ($urandom_range(0, 7) == 0)
                  send_request(susi_pkg::CMD_READ, 32'($urandom), 6'($urandom_range(0, 63)));
            end
            send_request(susi_pkg::CMD_READ, 32'($urandom), 6'd63);
            repeat (8)
               send_request(susi_pkg::CMD_READ, 32'($urandom), 6'($urandom_range(0, 63)));
            repeat (10) begin
               if ($urandom_range(0, 1) == 0 && recent_keys.size() > 0)
                  send_request(susi_pkg::CMD_INSERT,
                               recent_keys[$urandom_range(0, recent_keys.size()-1)],
                               6'($urandom));
               else
                  send_request(susi_pkg::CMD_INSERT, 32'($urandom), 6'($urandom));
            end
         end else begin
            // mixed traffic around a narrow key window
            base = 32'($urandom);
            if ($urandom_range(0, 3) == 0) base = 32'hFFFF_FFF0;
            len = $urandom_range(20, 60);
            repeat (len) begin
               pick = $urandom_range(0, 99);
               if (pick < 50)
                  send_request(susi_pkg::CMD_INSERT, window_key(base), 6'($urandom));
               else if (pick < 85)
                  send_request(susi_pkg::CMD_READ, 32'($urandom),
                               $urandom_range(0, 1) ? 6'($urandom)
                                                    : 6'($urandom_range(0, 15)));
               else if (pick < 90)
                  send_request(susi_pkg::CMD_CLEAR, 32'($urandom), 6'($urandom));
               else
                  send_request(CMD_UNUSED, 32'($urandom), 6'($urandom));
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain: wait for every owed response, then let any dropped request settle
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
